>>> sv/ec_affine_point_add_gfp_top_assert.svh
// assertion macros for the elliptic curve point adder
// no dependencies; included by the top level
`ifndef EC_AFFINE_POINT_ADD_GFP_TOP_ASSERT_SVH
`define EC_AFFINE_POINT_ADD_GFP_TOP_ASSERT_SVH
`define EC_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define EC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

>>> sv/ecpa_pkg.sv
// shared constants for the elliptic curve point adder
// no dependencies
package ecpa_pkg;
  localparam int unsigned REG_COEFF_A = 0;
  localparam int unsigned REG_PRIME   = 1;
  localparam int unsigned PRIME_RESET = 32'd4294967291;
endpackage

>>> sv/ecpa_modmul.sv
// bit-serial modular multiplier, one operand bit per cycle
// depends on nothing; used by the top level
module ecpa_modmul #(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         go,
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  logic [W-1:0] m,
  output logic         done,
  output logic [W-1:0] p
);
  localparam int CW = $clog2(W + 1);
  logic [W-1:0]  acc;
  logic [W-1:0]  bsh;
  logic [CW-1:0] cnt;
  logic          run;
  logic [W:0]    dbl;
  logic [W-1:0]  d1;
  logic [W:0]    ad;
  logic [W-1:0]  d2;

  always_comb begin
    dbl = {1'b0, acc} + {1'b0, acc};
    d1 = (dbl >= {1'b0, m}) ? W'(dbl - {1'b0, m}) : dbl[W-1:0];
    ad = {1'b0, d1} + {1'b0, a};
    d2 = bsh[W-1] ? ((ad >= {1'b0, m}) ? W'(ad - {1'b0, m}) : ad[W-1:0]) : d1;
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      run <= 1'b0;
      cnt <= '0;
    end else if (go) begin
      run <= 1'b1;
      acc <= '0;
      bsh <= b;
      cnt <= CW'(W);
    end else if (run) begin
      acc <= d2;
      bsh <= bsh << 1;
      cnt <= cnt - 1'b1;
      if (cnt == CW'(1)) begin
        run  <= 1'b0;
        done <= 1'b1;
      end
    end
  end
  assign p = acc;
endmodule

>>> sv/ec_affine_point_add_gfp_top.sv
// elliptic curve affine point addition over gf(p), top level
// depends on ecpa_pkg, ecpa_modmul and the assertion header
//
// usage: pulse start while busy is low with the two points on first_x/y,
// second_x/y. busy stays high while the item is worked. when done the sum
// appears on sum_x, sum_y, at_infinity for exactly one cycle with out_valid
// high; the receiver cannot stall and must take it then.
// configuration: cfg_valid/cfg_ready with cfg_index (0 = coeff a,
// 1 = prime) and cfg_data; cfg_ready is high whenever busy is low.
// operation: inputs and a are reduced mod p by a restoring remainder, one
// bit per cycle. every product uses one shared bit-serial multiplier. the
// inversion d^(p-2) takes up to 2W products. a new item can be taken in
// the result cycle.
// reset clears control state, sets a = 0 and p = 4294967291 (truncated to W).
`include "ec_affine_point_add_gfp_top_assert.svh"
module ec_affine_point_add_gfp_top #(
  parameter int FIELD_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [FIELD_BITS-1:0] first_x,
  input  logic [FIELD_BITS-1:0] first_y,
  input  logic [FIELD_BITS-1:0] second_x,
  input  logic [FIELD_BITS-1:0] second_y,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic                  cfg_index,
  input  logic [FIELD_BITS-1:0] cfg_data,
  output logic                  out_valid,
  output logic [FIELD_BITS-1:0] sum_x,
  output logic [FIELD_BITS-1:0] sum_y,
  output logic                  at_infinity
);
  localparam int W  = FIELD_BITS;
  localparam int CW = $clog2(W + 2);

  localparam logic [4:0] S_IDLE = 5'd0, S_RED = 5'd1, S_CHK = 5'd2, S_DBL0 = 5'd3,
    S_DBL1 = 5'd4, S_EXP = 5'd5, S_EXPS = 5'd6, S_SL = 5'd7, S_X3 = 5'd8,
    S_Y3 = 5'd9, S_OUT = 5'd10, S_EXPB = 5'd11;

  logic [4:0]   state;
  logic [W-1:0] ca, pm;
  logic [W-1:0] x1, y1, x2, y2, cr, num, den, r, base, e, s, x3;
  logic [2:0]   ridx;
  logic [W-1:0] rem, dvd;
  logic [CW-1:0] rcnt;
  logic         mgo, mdone;
  logic [W-1:0] ma, mb, mp;

  function automatic logic [W-1:0] addm(input logic [W-1:0] u, v, m);
    logic [W:0] t;
    t = {1'b0, u} + {1'b0, v};
    return (t >= {1'b0, m}) ? W'(t - {1'b0, m}) : t[W-1:0];
  endfunction
  function automatic logic [W-1:0] subm(input logic [W-1:0] u, v, m);
    return (u >= v) ? W'(u - v) : W'(m - (v - u));
  endfunction

  ecpa_modmul #(.W(W)) u_mul (.clk(clk), .rst(rst), .go(mgo), .a(ma), .b(mb), .m(pm),
    .done(mdone), .p(mp));

  assign busy = (state != S_IDLE);
  assign cfg_ready = !busy;

  logic [W:0] rsh;
  always_comb rsh = {rem, dvd[W-1]};

  always_ff @(posedge clk) begin
    mgo <= 1'b0;
    out_valid <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
      ca <= '0;
      pm <= W'(ecpa_pkg::PRIME_RESET);
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cfg_valid && cfg_ready) begin
            if (cfg_index == 1'(ecpa_pkg::REG_COEFF_A)) ca <= cfg_data;
            else pm <= cfg_data;
          end
          if (start) begin
            x1 <= first_x; y1 <= first_y; x2 <= second_x; y2 <= second_y;
            if (pm < W'(3)) begin
              sum_x <= '0; sum_y <= '0; at_infinity <= 1'b1;
              state <= S_OUT;
            end else begin
              ridx <= '0; rem <= '0; dvd <= first_x; rcnt <= CW'(W);
              state <= S_RED;
            end
          end
        end
        S_RED: begin
          if (rcnt != '0) begin
            rem <= (rsh >= {1'b0, pm}) ? W'(rsh - {1'b0, pm}) : rsh[W-1:0];
            dvd <= dvd << 1;
            rcnt <= rcnt - 1'b1;
          end else begin
            case (ridx)
              3'd0: begin x1 <= rem; dvd <= y1; end
              3'd1: begin y1 <= rem; dvd <= x2; end
              3'd2: begin x2 <= rem; dvd <= y2; end
              3'd3: begin y2 <= rem; dvd <= ca; end
              default: cr <= rem;
            endcase
            rem <= '0; rcnt <= CW'(W); ridx <= ridx + 1'b1;
            if (ridx == 3'd4) state <= S_CHK;
          end
        end
        S_CHK: begin
          if (x1 == x2 && y1 == subm('0, y2, pm)) begin
            sum_x <= '0; sum_y <= '0; at_infinity <= 1'b1;
            state <= S_OUT;
          end else if (x1 == x2 && y1 == y2) begin
            den <= addm(y1, y1, pm);
            ma <= x1; mb <= x1; mgo <= 1'b1;
            state <= S_DBL0;
          end else begin
            num <= subm(y2, y1, pm);
            den <= subm(x2, x1, pm);
            state <= S_EXPB;
          end
        end
        S_DBL0: if (mdone) begin
          num <= addm(addm(addm(mp, mp, pm), mp, pm), cr, pm);
          state <= S_EXPB;
        end
        S_EXPB: begin
          r <= W'(1); base <= den; e <= pm - W'(2);
          state <= S_EXP;
        end
        S_EXP: begin
          if (e == '0) begin
            ma <= num; mb <= r; mgo <= 1'b1; state <= S_SL;
          end else if (e[0]) begin
            ma <= r; mb <= base; mgo <= 1'b1; state <= S_DBL1;
          end else begin
            ma <= base; mb <= base; mgo <= 1'b1; state <= S_EXPS;
          end
        end
        S_DBL1: if (mdone) begin
          r <= mp; ma <= base; mb <= base; mgo <= 1'b1; state <= S_EXPS;
        end
        S_EXPS: if (mdone) begin
          base <= mp; e <= e >> 1; state <= S_EXP;
        end
        S_SL: if (mdone) begin
          s <= mp; ma <= mp; mb <= mp; mgo <= 1'b1; state <= S_X3;
        end
        S_X3: if (mdone) begin
          x3 <= subm(subm(mp, x1, pm), x2, pm);
          ma <= s; mb <= subm(x1, subm(subm(mp, x1, pm), x2, pm), pm);
          mgo <= 1'b1; state <= S_Y3;
        end
        S_Y3: if (mdone) begin
          sum_x <= x3; sum_y <= subm(mp, y1, pm); at_infinity <= 1'b0;
          state <= S_OUT;
        end
        S_OUT: begin
          out_valid <= 1'b1; state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `EC_ASSERT_IMPL(a_idle_no_out, clk, rst, out_valid, state == S_IDLE)
  `EC_ASSERT_NEXT(a_start_busy, clk, rst, start && !busy, busy)
  `EC_ASSERT_IMPL(a_inf_zero, clk, rst, out_valid && at_infinity, sum_x == '0 && sum_y == '0)
  `EC_ASSERT_IMPL(a_mul_idle, clk, rst, mgo, busy)
endmodule
